// File: sv/ngh_pkg.sv
// ----------------------------------------------------------------------------
// ngh_pkg
// shared types and constants of the noise gate with hold and gain smoothing
// ----------------------------------------------------------------------------
package ngh_pkg;

  // gain format q1.16
  localparam int GAIN_FRAC = 16;
  localparam int GAIN_W    = 17;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_CLOSE     = 2'd1,
    REG_OPEN      = 2'd2,
    REG_HOLD      = 2'd3
  } reg_index_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CORR = 4'b0010,
    S_GAIN = 4'b0100,
    S_PROD = 4'b1000
  } state_t;

endpackage

// File: sv/noise_gate_hold_smooth_unit.sv
// ----------------------------------------------------------------------------
// noise_gate_hold_smooth_unit
// noise gate: threshold compare, hold counter, one-pole gain smoothing
// ----------------------------------------------------------------------------
// a word is accepted only in idle and passes the correction, gain update and
//   product states; one shared multiplier serves the smoothing step and then
//   the output product, so the next word is taken only once the last is done
// a finished word may wait in the output register while the next is taken
// reset (rst, synchronous): gain, hold counter, configuration and output valid go to zero, state to idle
module noise_gate_hold_smooth_unit #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
) (
  input  logic clk,
  input  logic rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,  // [SW-1:0] sample_in
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [((SAMPLE_WIDTH+17+7)/8)*8-1:0] m_tdata // sample_out, gain_now
);
  import ngh_pkg::*;

  localparam int TW_OUT = ((SAMPLE_WIDTH + GAIN_W + 7) / 8) * 8;
  // compare width covers magnitude (SW+1 bits) and the 16-bit threshold
  localparam int CMPW   = (SAMPLE_WIDTH + 1 > 17) ? SAMPLE_WIDTH + 1 : 17;
  // shared multiplier operand widths
  localparam int MA     = (SAMPLE_WIDTH > COEF_WIDTH + 1) ? SAMPLE_WIDTH : COEF_WIDTH + 1;
  localparam int MB     = GAIN_W + 1;
  localparam int MP     = MA + MB;
  localparam logic [CMPW-1:0] FULL_SCALE = CMPW'(1) << (SAMPLE_WIDTH - 1);

  // configuration registers
  logic [15:0]           threshold_level;
  logic [COEF_WIDTH-1:0] close_coef;
  logic [COEF_WIDTH-1:0] open_coef;
  logic [15:0]           hold_samples;

  // block state
  state_t            state;
  logic [GAIN_W-1:0] cur_gain;
  logic [GAIN_W-1:0] hold_count;

  // per-word working registers
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic [COEF_WIDTH-1:0]          coef_r;
  logic [GAIN_W-1:0]              diff_r;   // |gain - target|
  logic [GAIN_W-1:0]              corr_r;   // truncated correction term
  logic                           tgt_one;  // target gain is 1.0
  logic                           upd_r;    // gain moves this word

  // output register
  logic signed [SAMPLE_WIDTH-1:0] out_sample;
  logic [GAIN_W-1:0]              out_gain;

  // front-end decision
  logic signed [SAMPLE_WIDTH-1:0] s_sample;
  logic [CMPW-1:0]                mag;
  logic [CMPW-1:0]                thr;
  logic                           target_one;
  logic                           falling;
  logic                           accept;

  // shared multiplier
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [MP-1:0] mul_p;

  logic [GAIN_W-1:0] gain_next;
  logic              out_free;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign s_sample = s_tdata[SAMPLE_WIDTH-1:0];

  always_comb begin
    // magnitude, with room for the most negative sample
    if (s_sample[SAMPLE_WIDTH-1]) begin
      mag = CMPW'(-(CMPW'(s_sample)));
    end else begin
      mag = CMPW'(s_sample);
    end
    // threshold saturates at full scale
    thr = CMPW'(threshold_level);
    if (thr > FULL_SCALE) begin
      thr = FULL_SCALE;
    end
    target_one = (mag >= thr);
    // target below gain only when target is zero and gain is nonzero
    falling    = !target_one && (cur_gain != '0);
  end

  // operand select: coef * diff first, then sample * new gain
  always_comb begin
    if (state == S_PROD) begin
      mul_a = MA'(sample_r);
      mul_b = MB'($signed({1'b0, cur_gain}));
    end else begin
      mul_a = MA'($signed({1'b0, coef_r}));
      mul_b = MB'($signed({1'b0, diff_r}));
    end
    mul_p = mul_a * mul_b;
  end

  // one-pole step never overshoots the target
  always_comb begin
    if (!upd_r) begin
      gain_next = cur_gain;
    end else if (tgt_one) begin
      gain_next = GAIN_ONE - corr_r;
    end else begin
      gain_next = corr_r;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_level <= '0;
      close_coef      <= '0;
      open_coef       <= '0;
      hold_samples    <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_THRESHOLD: threshold_level <= cfg_data;
        REG_CLOSE:     close_coef      <= COEF_WIDTH'(cfg_data);
        REG_OPEN:      open_coef       <= COEF_WIDTH'(cfg_data);
        REG_HOLD:      hold_samples    <= cfg_data;
      endcase
    end
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_gain   <= '0;
      hold_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // a new word replaces the one taken in the same cycle
      if (state == S_PROD && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (falling) begin
              if (hold_count > GAIN_W'(hold_samples)) begin
                // hold expired, decay with the closing coefficient
                upd_r <= 1'b1;
              end else begin
                upd_r      <= 1'b0;
                hold_count <= hold_count + 1'b1;
              end
              coef_r <= close_coef;
            end else begin
              hold_count <= '0;
              upd_r      <= 1'b1;
              coef_r     <= open_coef;
            end
            tgt_one  <= target_one;
            diff_r   <= target_one ? GAIN_ONE - cur_gain : cur_gain;
            sample_r <= s_sample;
            state    <= S_CORR;
          end
        end
        S_CORR: begin
          corr_r <= mul_p[COEF_WIDTH +: GAIN_W];
          state  <= S_GAIN;
        end
        S_GAIN: begin
          cur_gain <= gain_next;
          state    <= S_PROD;
        end
        S_PROD: begin
          // wait here while the previous word is still unread
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output payload, product floored by the arithmetic shift
  always_ff @(posedge clk) begin
    if (state == S_PROD && out_free) begin
      out_sample <= mul_p[GAIN_FRAC +: SAMPLE_WIDTH];
      out_gain   <= cur_gain;
    end
  end

  assign m_tdata = TW_OUT'({out_gain, out_sample});

`ifndef SYNTHESIS
  // gain stays within q1.16 unity
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    cur_gain <= GAIN_ONE)
    else $error("smoothed gain above unity");

  // hold counter never passes one above the largest hold count
  a_hold_range: assert property (@(posedge clk) disable iff (rst)
    hold_count <= GAIN_ONE)
    else $error("hold counter out of range");

  // gain changes only in the update step
  a_gain_update: assert property (@(posedge clk) disable iff (rst)
    (state != S_GAIN) |=> $stable(cur_gain))
    else $error("gain changed outside update step");

  // an accepted word leaves the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("ready right after accept");
`endif

endmodule
